// ----- hw/rtl/i2c_master_byte_transfer_defines.svh -----
// ---------------------------------------------------------------------------
// I2C master byte transfer: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_TRANSFER_DEFINES_SVH
`define I2C_MASTER_BYTE_TRANSFER_DEFINES_SVH

// same-cycle implication
`define I2CM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cm assertion failed");

// next-cycle implication
`define I2CM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cm assertion failed");

`endif

// ----- hw/rtl/i2cm_pkg.sv -----
// ---------------------------------------------------------------------------
// I2C master byte transfer: package
// Counter width and beat field positions shared by the block and its checker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

    localparam int COUNT_BITS = 8;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 32;

    // input beat
    localparam int S_REQ_LSB   = 0;
    localparam int S_ADDR_LSB  = 1;
    localparam int S_ISRD_LSB  = 9;
    localparam int S_COUNT_LSB = 10;
    localparam int S_WBYTE_LSB = 18;
    localparam int S_SCL_LSB   = 26;
    localparam int S_SDA_LSB   = 27;

    // output beat
    localparam int M_SCL_LSB   = 0;
    localparam int M_SDA_LSB   = 1;
    localparam int M_BUSY_LSB  = 2;
    localparam int M_INDEX_LSB = 3;
    localparam int M_RBYTE_LSB = 11;
    localparam int M_RVAL_LSB  = 19;
    localparam int M_XFER_LSB  = 20;
    localparam int M_USED_W    = 28;

endpackage

`default_nettype wire

// ----- hw/rtl/i2c_master_byte_transfer.sv -----
// ---------------------------------------------------------------------------
// I2C master byte transfer
// Open-drain I2C master sequencer: start, address, data bytes, stop.
// ---------------------------------------------------------------------------
// Usage:
//   Each input beat on s_* is one bus phase tick: sampled SCL/SDA levels plus
//   an optional transaction request (taken only while idle). Every accepted
//   beat produces exactly one output beat on m_* with the pin drives, status,
//   byte index and any received byte; m_tlast marks the tick the stop ends.
//   Output beats are registered. Throughput: 1 beat per cycle while m_tready
//   is high, set by the single registered sequencer step per tick.
//   Each bit costs four ticks (more while a target stretches SCL low).
//   Reset: sequencer idle, pins released, output register empty.
//   Stall: the output register holds its beat while m_tready is low; a new
//   input beat is taken in the cycle the held beat leaves, so s_tready is
//   low only while a beat waits and m_tready is low.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_byte_transfer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // request, target_address[8], is_read, byte_count[8], write_byte[8],
    // scl_in, sda_in, zero fill
    input  wire logic [i2cm_pkg::S_DATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // scl_pull_low, sda_pull_low, busy_res, byte_index[8], read_byte[8],
    // read_valid, transferred[8], zero fill
    output logic [i2cm_pkg::M_DATA_W-1:0]      m_tdata,
    // done_res
    output logic                               m_tlast
);

    import i2cm_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_LOW       = 4'd1,
        PH_DATA      = 4'd2,
        PH_HIGH      = 4'd3,
        PH_WAIT      = 4'd4,
        PH_STOP_LOW  = 4'd5,
        PH_STOP_DATA = 4'd6,
        PH_STOP_HIGH = 4'd7,
        PH_STOP_WAIT = 4'd8
    } phase_t;

    localparam logic [3:0] ACK_BIT = 4'd8;

    phase_t                phase_reg, phase_next;
    logic [3:0]            bit_cnt_reg, bit_cnt_next;
    logic [7:0]            shift_reg, shift_next;
    logic [COUNT_BITS-1:0] done_cnt_reg, done_cnt_next;
    logic [COUNT_BITS-1:0] want_cnt_reg, want_cnt_next;
    logic                  read_mode_reg, read_mode_next;
    logic                  scl_drv_reg, scl_drv_next;
    logic                  sda_drv_reg, sda_drv_next;
    logic                  addr_stage_reg, addr_stage_next;

    logic                  out_valid_reg;
    logic [M_DATA_W-1:0]   out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;

    logic                  in_req, in_isrd, in_scl, in_sda;
    logic [7:0]            in_addr, in_count, in_wbyte;
    logic                  accept;
    logic                  byte_out, master_drv, go_on;
    logic                  rvalid, done;
    logic [7:0]            rbyte, xfer;
    logic [COUNT_BITS-1:0] cnt_inc;

    assign in_req   = s_tdata[S_REQ_LSB];
    assign in_addr  = s_tdata[S_ADDR_LSB +: 8];
    assign in_isrd  = s_tdata[S_ISRD_LSB];
    assign in_count = s_tdata[S_COUNT_LSB +: 8];
    assign in_wbyte = s_tdata[S_WBYTE_LSB +: 8];
    assign in_scl   = s_tdata[S_SCL_LSB];
    assign in_sda   = s_tdata[S_SDA_LSB];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign byte_out   = addr_stage_reg || !read_mode_reg;
    assign master_drv = (bit_cnt_reg < ACK_BIT) ? byte_out : !byte_out;
    assign cnt_inc    = done_cnt_reg + COUNT_BITS'(1);

    always_comb
    begin
        phase_next      = phase_reg;
        bit_cnt_next    = bit_cnt_reg;
        shift_next      = shift_reg;
        done_cnt_next   = done_cnt_reg;
        want_cnt_next   = want_cnt_reg;
        read_mode_next  = read_mode_reg;
        scl_drv_next    = scl_drv_reg;
        sda_drv_next    = sda_drv_reg;
        addr_stage_next = addr_stage_reg;
        rvalid          = 1'b0;
        rbyte           = 8'd0;
        done            = 1'b0;
        xfer            = 8'd0;
        go_on           = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (in_req)
                begin
                    shift_next      = in_addr;
                    read_mode_next  = in_isrd;
                    want_cnt_next   = COUNT_BITS'(in_count);
                    done_cnt_next   = '0;
                    bit_cnt_next    = 4'd0;
                    addr_stage_next = 1'b1;
                    sda_drv_next    = 1'b1;
                    phase_next      = PH_LOW;
                end
            end
            PH_LOW:
            begin
                scl_drv_next = 1'b1;
                phase_next   = PH_DATA;
            end
            PH_DATA:
            begin
                if (master_drv)
                begin
                    if (bit_cnt_reg < ACK_BIT)
                    begin
                        if (bit_cnt_reg == 4'd0 && !addr_stage_reg)
                        begin
                            shift_next = in_wbyte;
                        end
                        sda_drv_next = !shift_next[7];
                    end
                    else
                    begin
                        sda_drv_next = 1'b1;  // master ACK
                    end
                end
                else
                begin
                    sda_drv_next = 1'b0;
                end
                phase_next = PH_HIGH;
            end
            PH_HIGH:
            begin
                scl_drv_next = 1'b0;
                phase_next   = PH_WAIT;
            end
            PH_WAIT:
            begin
                if (in_scl)
                begin
                    if (bit_cnt_reg < ACK_BIT)
                    begin
                        shift_next   = {shift_reg[6:0], master_drv ? 1'b0 : in_sda};
                        bit_cnt_next = bit_cnt_reg + 4'd1;
                        phase_next   = PH_LOW;
                    end
                    else
                    begin
                        if (addr_stage_reg)
                        begin
                            addr_stage_next = 1'b0;
                            go_on = !in_sda && (want_cnt_reg != '0);
                        end
                        else if (read_mode_reg)
                        begin
                            rvalid        = 1'b1;
                            rbyte         = shift_reg;
                            done_cnt_next = cnt_inc;
                            go_on         = cnt_inc != want_cnt_reg;
                        end
                        else if (!in_sda)
                        begin
                            done_cnt_next = cnt_inc;
                            go_on         = cnt_inc != want_cnt_reg;
                        end
                        bit_cnt_next = 4'd0;
                        phase_next   = go_on ? PH_LOW : PH_STOP_LOW;
                    end
                end
            end
            PH_STOP_LOW:
            begin
                scl_drv_next = 1'b1;
                phase_next   = PH_STOP_DATA;
            end
            PH_STOP_DATA:
            begin
                sda_drv_next = 1'b1;
                phase_next   = PH_STOP_HIGH;
            end
            PH_STOP_HIGH:
            begin
                scl_drv_next = 1'b0;
                phase_next   = PH_STOP_WAIT;
            end
            PH_STOP_WAIT:
            begin
                if (in_scl)
                begin
                    sda_drv_next = 1'b0;
                    done         = 1'b1;
                    xfer         = 8'(done_cnt_reg);
                    phase_next   = PH_IDLE;
                end
            end
            default:
            begin
                scl_drv_next = 1'b0;
                sda_drv_next = 1'b0;
                phase_next   = PH_IDLE;
            end
        endcase

        out_data_next = '0;
        out_data_next[M_SCL_LSB]        = scl_drv_next;
        out_data_next[M_SDA_LSB]        = sda_drv_next;
        out_data_next[M_BUSY_LSB]       = phase_next != PH_IDLE;
        out_data_next[M_INDEX_LSB +: 8] = 8'(done_cnt_next);
        out_data_next[M_RBYTE_LSB +: 8] = rbyte;
        out_data_next[M_RVAL_LSB]       = rvalid;
        out_data_next[M_XFER_LSB +: 8]  = xfer;
        out_last_next = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_cnt_reg    <= 4'd0;
            shift_reg      <= 8'd0;
            done_cnt_reg   <= '0;
            want_cnt_reg   <= '0;
            read_mode_reg  <= 1'b0;
            scl_drv_reg    <= 1'b0;
            sda_drv_reg    <= 1'b0;
            addr_stage_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg      <= phase_next;
                bit_cnt_reg    <= bit_cnt_next;
                shift_reg      <= shift_next;
                done_cnt_reg   <= done_cnt_next;
                want_cnt_reg   <= want_cnt_next;
                read_mode_reg  <= read_mode_next;
                scl_drv_reg    <= scl_drv_next;
                sda_drv_reg    <= sda_drv_next;
                addr_stage_reg <= addr_stage_next;
                out_valid_reg  <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/i2cm_checker.sv -----
// ---------------------------------------------------------------------------
// I2C master byte transfer: port checker
// Watches the top-level beats and flags inconsistent outputs or stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_master_byte_transfer_defines.svh"

module i2cm_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [i2cm_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic                          m_tlast
);

    import i2cm_pkg::*;

    logic zero_ok;

    assign zero_ok = (m_tdata[M_RVAL_LSB] || m_tdata[M_RBYTE_LSB +: 8] == 8'd0)
                  && (m_tlast || m_tdata[M_XFER_LSB +: 8] == 8'd0)
                  && m_tdata[M_DATA_W-1:M_USED_W] == '0;

    // held beat stays put while stalled
    `I2CM_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tlast}))
    // input side never blocks while the output register is free
    `I2CM_ASSERT_NOW(a_ready, !m_tvalid, s_tready)
    // every accepted input beat shows up on the output next cycle
    `I2CM_ASSERT_NEXT(a_accept_out, s_tvalid && s_tready, m_tvalid)
    // stop ends the transaction: busy drops on the done beat
    `I2CM_ASSERT_NOW(a_done_idle, m_tvalid && m_tlast, !m_tdata[M_BUSY_LSB])
    // received byte and count are zero unless flagged
    `I2CM_ASSERT_NOW(a_zero_fill, m_tvalid, zero_ok)

endmodule

bind i2c_master_byte_transfer i2cm_checker u_i2cm_checker (.*);

`default_nettype wire

// ----- tb/sv/i2cm_beat_compare.sv -----
// ----------------------------------------------------------------------------
// I2C master byte transfer: beat compare
// Watches both stream channels. Each accepted input tick is run through a
// local model of the bus sequencer, and the resulting pin/status beat is
// queued. Each accepted output beat is checked field by field against the
// oldest queued beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cm_beat_compare
    import i2cm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic                m_tlast,
    output int                  errors,
    output int                  pending,
    output int                  stops_seen,
    output int                  bytes_read
);

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_SCL_LOW,
        SEQ_SET_SDA,
        SEQ_SCL_REL,
        SEQ_SCL_WAIT,
        SEQ_P_LOW,
        SEQ_P_SDA,
        SEQ_P_REL,
        SEQ_P_WAIT
    } seq_state_t;

    typedef struct packed {
        logic       request;
        logic [7:0] addr;
        logic       is_read;
        logic [7:0] count;
        logic [7:0] wbyte;
        logic       scl;
        logic       sda;
    } bus_tick_t;

    typedef struct packed {
        logic       scl_low;
        logic       sda_low;
        logic       busy;
        logic [7:0] index;
        logic [7:0] rbyte;
        logic       rvalid;
        logic       done;
        logic [7:0] xfer;
    } pin_beat_t;

    seq_state_t            seq_phase;
    logic [3:0]            bit_idx;
    logic [7:0]            shifter;
    logic [COUNT_BITS-1:0] bytes_done;
    logic [COUNT_BITS-1:0] bytes_wanted;
    logic                  reading;
    logic                  scl_hold;
    logic                  sda_hold;
    logic                  sending_addr;

    pin_beat_t pin_beats_due[$];

    function automatic logic master_on_sda();
        logic byte_out;
        byte_out = sending_addr || !reading;
        return (bit_idx < 4'd8) ? byte_out : !byte_out;
    endfunction

    task automatic clear_sequencer();
        seq_phase    = SEQ_IDLE;
        bit_idx      = '0;
        shifter      = '0;
        bytes_done   = '0;
        bytes_wanted = '0;
        reading      = 1'b0;
        scl_hold     = 1'b0;
        sda_hold     = 1'b0;
        sending_addr = 1'b0;
    endtask

    task automatic step_sequencer(input bus_tick_t tk, output pin_beat_t res);
        logic go_on;
        logic bitv;
        res = '0;
        case (seq_phase)
            SEQ_IDLE:
            begin
                if (tk.request)
                begin
                    shifter      = tk.addr;
                    reading      = tk.is_read;
                    bytes_wanted = tk.count;
                    bytes_done   = '0;
                    bit_idx      = '0;
                    sending_addr = 1'b1;
                    sda_hold     = 1'b1;
                    seq_phase    = SEQ_SCL_LOW;
                end
            end
            SEQ_SCL_LOW:
            begin
                scl_hold  = 1'b1;
                seq_phase = SEQ_SET_SDA;
            end
            SEQ_SET_SDA:
            begin
                if (master_on_sda())
                begin
                    bitv = 1'b0;
                    if (bit_idx < 4'd8)
                    begin
                        if (bit_idx == 4'd0 && !sending_addr)
                            shifter = tk.wbyte;
                        bitv = shifter[7];
                    end
                    sda_hold = ~bitv;
                end
                else
                    sda_hold = 1'b0;
                seq_phase = SEQ_SCL_REL;
            end
            SEQ_SCL_REL:
            begin
                scl_hold  = 1'b0;
                seq_phase = SEQ_SCL_WAIT;
            end
            SEQ_SCL_WAIT:
            begin
                if (tk.scl)
                begin
                    if (bit_idx < 4'd8)
                    begin
                        if (master_on_sda())
                            shifter = {shifter[6:0], 1'b0};
                        else
                            shifter = {shifter[6:0], tk.sda};
                        bit_idx   = bit_idx + 4'd1;
                        seq_phase = SEQ_SCL_LOW;
                    end
                    else
                    begin
                        if (sending_addr)
                        begin
                            sending_addr = 1'b0;
                            go_on = !tk.sda && (bytes_wanted != '0);
                        end
                        else if (reading)
                        begin
                            res.rvalid = 1'b1;
                            res.rbyte  = shifter;
                            bytes_done = bytes_done + 1'b1;
                            go_on      = bytes_done != bytes_wanted;
                        end
                        else if (!tk.sda)
                        begin
                            bytes_done = bytes_done + 1'b1;
                            go_on      = bytes_done != bytes_wanted;
                        end
                        else
                            go_on = 1'b0;
                        bit_idx   = '0;
                        seq_phase = go_on ? SEQ_SCL_LOW : SEQ_P_LOW;
                    end
                end
            end
            SEQ_P_LOW:
            begin
                scl_hold  = 1'b1;
                seq_phase = SEQ_P_SDA;
            end
            SEQ_P_SDA:
            begin
                sda_hold  = 1'b1;
                seq_phase = SEQ_P_REL;
            end
            SEQ_P_REL:
            begin
                scl_hold  = 1'b0;
                seq_phase = SEQ_P_WAIT;
            end
            SEQ_P_WAIT:
            begin
                if (tk.scl)
                begin
                    sda_hold  = 1'b0;
                    res.done  = 1'b1;
                    res.xfer  = bytes_done;
                    seq_phase = SEQ_IDLE;
                end
            end
            default:
            begin
                scl_hold  = 1'b0;
                sda_hold  = 1'b0;
                seq_phase = SEQ_IDLE;
            end
        endcase
        res.scl_low = scl_hold;
        res.sda_low = sda_hold;
        res.busy    = seq_phase != SEQ_IDLE;
        res.index   = bytes_done;
    endtask

    function automatic void cmp_field(string what, int unsigned want, int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        bus_tick_t tk;
        pin_beat_t want;
        pin_beat_t got;
        if (!rst_n)
        begin
            clear_sequencer();
            pin_beats_due.delete();
            errors     = 0;
            stops_seen = 0;
            bytes_read = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.scl_low = m_tdata[M_SCL_LSB];
                got.sda_low = m_tdata[M_SDA_LSB];
                got.busy    = m_tdata[M_BUSY_LSB];
                got.index   = m_tdata[M_INDEX_LSB +: 8];
                got.rbyte   = m_tdata[M_RBYTE_LSB +: 8];
                got.rvalid  = m_tdata[M_RVAL_LSB];
                got.xfer    = m_tdata[M_XFER_LSB +: 8];
                got.done    = m_tlast;
                if (pin_beats_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: output beat %h with no beat expected", $time, got);
                end
                else
                begin
                    want = pin_beats_due.pop_front();
                    cmp_field("scl_pull_low", want.scl_low, got.scl_low);
                    cmp_field("sda_pull_low", want.sda_low, got.sda_low);
                    cmp_field("busy_res", want.busy, got.busy);
                    cmp_field("byte_index", want.index, got.index);
                    cmp_field("read_byte", want.rbyte, got.rbyte);
                    cmp_field("read_valid", want.rvalid, got.rvalid);
                    cmp_field("done_res", want.done, got.done);
                    cmp_field("transferred", want.xfer, got.xfer);
                    if (want.done)
                        stops_seen++;
                    if (want.rvalid)
                        bytes_read++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                tk.request = s_tdata[S_REQ_LSB];
                tk.addr    = s_tdata[S_ADDR_LSB +: 8];
                tk.is_read = s_tdata[S_ISRD_LSB];
                tk.count   = s_tdata[S_COUNT_LSB +: 8];
                tk.wbyte   = s_tdata[S_WBYTE_LSB +: 8];
                tk.scl     = s_tdata[S_SCL_LSB];
                tk.sda     = s_tdata[S_SDA_LSB];
                step_sequencer(tk, want);
                pin_beats_due.push_back(want);
            end
        end
        pending = pin_beats_due.size();
    end

endmodule

// ----- tb/sv/tb_i2c_master_byte_transfer.sv -----
// ----------------------------------------------------------------------------
// I2C master byte transfer: testbench top
// Plays the bus side of the master one tick per beat: sampled SCL with
// random clock stretching, SDA answers biased toward ACK or NACK, and
// directed corner transactions padded with random noise ticks. Sender gaps
// and receiver stalls vary by phase, with one long output hold-off.
// Checking lives in i2cm_beat_compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_i2c_master_byte_transfer;
    import i2cm_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 2000;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    int errors;
    int pending;
    int stops_seen;
    int bytes_read;

    int   ticks_sent  = 0;
    int   gap_pct     = 0;
    int   stall_pct   = 0;
    int   hold_left   = 0;
    int   quiet_count = 0;
    logic hold_req    = 1'b0;
    logic hold_done   = 1'b0;

    i2c_master_byte_transfer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    i2cm_beat_compare u_compare (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .errors     (errors),
        .pending    (pending),
        .stops_seen (stops_seen),
        .bytes_read (bytes_read)
    );

    always #6 clk = ~clk;

    function automatic logic [S_DATA_W-1:0] pack_tick(logic req, logic [7:0] addr, logic rd,
                                                      logic [7:0] cnt, logic [7:0] wb,
                                                      logic scl, logic sda);
        logic [S_DATA_W-1:0] w;
        w = '0;
        w[S_REQ_LSB]         = req;
        w[S_ADDR_LSB +: 8]   = addr;
        w[S_ISRD_LSB]        = rd;
        w[S_COUNT_LSB +: 8]  = cnt;
        w[S_WBYTE_LSB +: 8]  = wb;
        w[S_SCL_LSB]         = scl;
        w[S_SDA_LSB]         = sda;
        return w;
    endfunction

    // called and returns at a falling edge
    task automatic send_tick(input logic [S_DATA_W-1:0] word);
        while ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        ticks_sent++;
        @(negedge clk);
    endtask

    // one transaction request, then bus ticks long enough to carry it out
    task automatic run_episode(input logic start, input logic rd, input logic [7:0] addr,
                               input logic [7:0] cnt, input int ack_pct,
                               input int stretch_pct);
        int   span;
        int   n_bits;
        int   n_ticks;
        logic req;
        if (ack_pct == 0)
            span = 0;
        else if (rd || cnt <= 8'd3)
            span = int'(cnt);
        else
            span = 3;
        n_bits  = 10 + 9 * span;
        n_ticks = 48 + 40 * span + 2 * n_bits * stretch_pct / (100 - stretch_pct)
                  + int'($urandom_range(8));
        send_tick(pack_tick(start, addr, rd, cnt, 8'($urandom), 1'b1, 1'b1));
        repeat (n_ticks)
        begin
            req = ($urandom_range(99) < 2);
            send_tick(pack_tick(req, 8'($urandom), 1'($urandom_range(1)),
                                8'($urandom_range(3)), 8'($urandom),
                                $urandom_range(99) >= stretch_pct,
                                $urandom_range(99) >= ack_pct));
        end
    endtask

    // receiver side: random stalls plus one long hold-off
    always @(negedge clk)
    begin : rx_side
        logic rdy;
        rdy = ($urandom_range(99) >= stall_pct);
        if (hold_left > 0)
        begin
            rdy       = 1'b0;
            hold_left = hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            rdy       = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            hold_done = 1'b1;
        end
        m_tready <= rdy;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_count <= 0;
        else if (quiet_count >= QUIET_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
            $display("i2c_master_byte_transfer regression: fail");
            $finish;
        end
        else
            quiet_count <= quiet_count + 1;
    end

    initial
    begin
        clk      = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // no idling, with the long output hold-off
        gap_pct   = 0;
        stall_pct = 0;
        hold_req  = 1'b1;
        // idle ticks at both field extremes
        send_tick(pack_tick(1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0));
        send_tick(pack_tick(1'b0, 8'hFF, 1'b1, 8'hFF, 8'hFF, 1'b1, 1'b1));
        // zero byte count after ACKed address
        run_episode(1'b1, 1'b0, 8'h00, 8'd0, 100, 0);
        // R/W bit says write, is_read says read
        run_episode(1'b1, 1'b1, 8'hA4, 8'd1, 50, 0);
        // address NACK, largest count
        run_episode(1'b1, 1'b0, 8'hFF, 8'd255, 0, 0);

        // sender idle most cycles: all ACKed write under heavy clock stretching
        gap_pct   = 83;
        stall_pct = 0;
        run_episode(1'b1, 1'b0, 8'h5A, 8'd1, 100, 40);

        // receiver stalling most cycles: long write ended by a data NACK
        gap_pct   = 0;
        stall_pct = 83;
        run_episode(1'b1, 1'b0, 8'h3C, 8'd255, 50, 0);

        // both idling: multi-byte read with stretching
        gap_pct   = 21;
        stall_pct = 21;
        run_episode(1'b1, 1'b1, 8'h81, 8'd2, 50, 20);

        gap_pct   = 0;
        stall_pct = 0;
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("Ran %0d bus ticks: %0d transfers closed by a stop, %0d bytes read.",
                 ticks_sent, stops_seen, bytes_read);
        $display("Covered NACKs, zero counts, stretched clocks and a long output hold-off.");
        if (errors == 0 && pending == 0)
            $display("i2c_master_byte_transfer regression: pass");
        else
            $display("i2c_master_byte_transfer regression: fail");
        $finish;
    end

endmodule
